>>> rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the SOH/STX frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int MAX_LEN = 32;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int LEN_W   = 6;
   localparam int IDX_W   = 5;
   localparam int WIN_LEN = 7;

   localparam logic [7:0] CH_SOH     = 8'h01;
   localparam logic [7:0] CH_STX     = 8'h02;
   localparam logic [7:0] CH_ETX     = 8'h03;
   localparam logic [7:0] CH_EOT     = 8'h04;
   localparam logic [7:0] FRAME_TYPE = 8'h55;
   localparam logic [7:0] BCAST_RST  = 8'hFF;

   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      STAT_ACCEPT  = 2'd0,
      STAT_BAD_SUM = 2'd1,
      STAT_NO_EOT  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_PAYLOAD,
      PH_ETX,
      PH_CSUM,
      PH_EOT,
      PH_READ,
      PH_LOAD
   } phase_type;

   typedef struct packed {
      logic shift_win;
      logic take_hdr;
      logic store_byte;
      logic take_csum;
      logic clear;
      logic load_status;
      logic emit_start;
      logic rd_issue;
      logic load_byte;
      logic next_idx;
   } cmd_type;

   typedef struct packed {
      logic hdr_ok;
      logic hdr_len_zero;
      logic len_zero;
      logic pay_done;
      logic etx_ok;
      logic frame_ok;
      logic byte_last;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/core/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// Frame phase state machine: sequences hunting, payload, trailer and output.
// ----------------------------------------------------------------------------
module sfr_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  sfr_pkg::sts_type sts,
   output sfr_pkg::cmd_type cmd
);
   import sfr_pkg::*;

   phase_type phase_ff;
   phase_type phase_in;
   logic      run_phase;
   logic      accept;

   always_comb begin
      case (phase_ff)
         PH_HUNT, PH_PAYLOAD, PH_ETX, PH_CSUM, PH_EOT: run_phase = 1'b1;
         default:                                      run_phase = 1'b0;
      endcase
   end

   assign req_tready = run_phase && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   // next state
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (accept && sts.hdr_ok) begin
               phase_in = sts.hdr_len_zero ? PH_ETX : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (accept && sts.pay_done) begin
               phase_in = PH_ETX;
            end
         end
         PH_ETX: begin
            if (accept) begin
               phase_in = sts.etx_ok ? PH_CSUM : PH_HUNT;
            end
         end
         PH_CSUM: begin
            if (accept) begin
               phase_in = PH_EOT;
            end
         end
         PH_EOT: begin
            if (accept) begin
               phase_in = (sts.frame_ok && !sts.len_zero) ? PH_READ : PH_HUNT;
            end
         end
         PH_READ: begin
            phase_in = PH_LOAD;
         end
         PH_LOAD: begin
            if (sts.out_free) begin
               phase_in = sts.byte_last ? PH_HUNT : PH_READ;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      case (phase_ff)
         PH_HUNT: begin
            cmd.shift_win = accept;
            cmd.take_hdr  = accept && sts.hdr_ok;
         end
         PH_PAYLOAD: begin
            cmd.store_byte = accept;
         end
         PH_ETX: begin
            cmd.clear = accept && !sts.etx_ok;
         end
         PH_CSUM: begin
            cmd.take_csum = accept;
         end
         PH_EOT: begin
            cmd.load_status = accept;
            cmd.emit_start  = accept && sts.frame_ok && !sts.len_zero;
            cmd.clear       = accept && !(sts.frame_ok && !sts.len_zero);
         end
         PH_READ: begin
            cmd.rd_issue = 1'b1;
         end
         PH_LOAD: begin
            cmd.load_byte = sts.out_free;
            cmd.next_idx  = sts.out_free && !sts.byte_last;
            cmd.clear     = sts.out_free && sts.byte_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

>>> rtl/core/sfr_datapath.sv
// ----------------------------------------------------------------------------
// sfr_datapath
// Header window, frame registers, checksum, payload memory and output register.
// ----------------------------------------------------------------------------
module sfr_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       rx_byte,
   input  logic             csr_valid,
   input  logic [7:0]       csr_data,
   input  sfr_pkg::cmd_type cmd,
   output sfr_pkg::sts_type sts,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);
   import sfr_pkg::*;

   logic [7:0]       bcast_ff, bcast_in;
   logic [7:0]       win_ff [WIN_LEN];
   logic [7:0]       win_in [WIN_LEN];
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       dest_ff, dest_in;
   logic [7:0]       sender_ff, sender_in;
   logic [7:0]       ack_ff, ack_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       rsum_ff, rsum_in;

   logic             out_valid_ff, out_valid_in;
   logic             out_kind_ff, out_kind_in;
   status_type       out_status_ff, out_status_in;
   logic [7:0]       out_dest_ff, out_dest_in;
   logic [7:0]       out_sender_ff, out_sender_in;
   logic [7:0]       out_ack_ff, out_ack_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   logic [7:0]       hdr_sum;
   logic             addr_ok;
   logic [LEN_W:0]   pos_next;
   logic [7:0]       ram_rd_data;
   status_type       frame_status;

   sfr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LEN)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // the new window is win_ff[1..6] followed by rx_byte
   assign addr_ok = (win_ff[3] == bcast_ff && win_ff[4] == bcast_ff)
                    || (win_ff[3] != win_ff[4]);
   assign hdr_sum = win_ff[2] + win_ff[3] + win_ff[4] + win_ff[5] + win_ff[6];
   assign pos_next = {1'b0, pos_ff} + {{LEN_W{1'b0}}, 1'b1};

   always_comb begin
      if (rx_byte != CH_EOT) begin
         frame_status = STAT_NO_EOT;
      end else if (rsum_ff != sum_ff) begin
         frame_status = STAT_BAD_SUM;
      end else begin
         frame_status = STAT_ACCEPT;
      end
   end

   always_comb begin
      sts.hdr_ok       = (win_ff[1] == CH_SOH) && (win_ff[2] == FRAME_TYPE)
                         && (rx_byte == CH_STX) && addr_ok
                         && ({1'b0, win_ff[6]} <= 9'(MAX_LEN));
      sts.hdr_len_zero = (win_ff[6] == 8'd0);
      sts.len_zero     = (len_ff == '0);
      sts.pay_done     = pos_next >= {1'b0, len_ff};
      sts.etx_ok       = (rx_byte == CH_ETX);
      sts.frame_ok     = (frame_status == STAT_ACCEPT);
      sts.byte_last    = (pos_next == {1'b0, len_ff});
      sts.out_free     = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      bcast_in  = csr_valid ? csr_data : bcast_ff;
      win_in    = win_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      dest_in   = dest_ff;
      sender_in = sender_ff;
      ack_in    = ack_ff;
      sum_in    = sum_ff;
      rsum_in   = rsum_ff;
      if (cmd.shift_win) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WIN_LEN-1] = rx_byte;
      end
      if (cmd.take_hdr) begin
         dest_in   = win_ff[3];
         sender_in = win_ff[4];
         ack_in    = win_ff[5];
         len_in    = win_ff[6][LEN_W-1:0];
         sum_in    = hdr_sum;
         pos_in    = '0;
      end
      if (cmd.store_byte) begin
         sum_in = sum_ff + rx_byte;
         pos_in = pos_next[LEN_W-1:0];
      end
      if (cmd.take_csum) begin
         rsum_in = rx_byte;
      end
      if (cmd.emit_start) begin
         pos_in = '0;
      end
      if (cmd.next_idx) begin
         pos_in = pos_next[LEN_W-1:0];
      end
      if (cmd.clear) begin
         pos_in  = '0;
         len_in  = '0;
         ack_in  = '0;
         sum_in  = '0;
         rsum_in = '0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_dest_in   = out_dest_ff;
      out_sender_in = out_sender_ff;
      out_ack_in    = out_ack_ff;
      out_len_in    = out_len_ff;
      out_idx_in    = out_idx_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (cmd.load_status || cmd.load_byte) begin
         out_valid_in  = 1'b1;
         out_dest_in   = dest_ff;
         out_sender_in = sender_ff;
         out_ack_in    = ack_ff;
         out_len_in    = len_ff;
      end
      if (cmd.load_status) begin
         out_kind_in   = KIND_STATUS;
         out_status_in = frame_status;
         out_idx_in    = '0;
         out_byte_in   = '0;
         out_last_in   = (frame_status != STAT_ACCEPT) || (len_ff == '0);
      end
      if (cmd.load_byte) begin
         out_kind_in   = KIND_PAYLOAD;
         out_status_in = STAT_ACCEPT;
         out_idx_in    = pos_ff[IDX_W-1:0];
         out_byte_in   = ram_rd_data;
         out_last_in   = (pos_next == {1'b0, len_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcast_ff     <= BCAST_RST;
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= '0;
         end
         pos_ff       <= '0;
         len_ff       <= '0;
         dest_ff      <= '0;
         sender_ff    <= '0;
         ack_ff       <= '0;
         sum_ff       <= '0;
         rsum_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bcast_ff     <= bcast_in;
         win_ff       <= win_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         dest_ff      <= dest_in;
         sender_ff    <= sender_in;
         ack_ff       <= ack_in;
         sum_ff       <= sum_in;
         rsum_ff      <= rsum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_dest_ff   <= out_dest_in;
      out_sender_ff <= out_sender_in;
      out_ack_ff    <= out_ack_in;
      out_len_ff    <= out_len_in;
      out_idx_ff    <= out_idx_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'b000, out_byte_ff, out_idx_ff, out_len_ff, out_ack_ff,
                        out_sender_ff, out_dest_ff, out_status_ff};

endmodule

>>> rtl/core/soh_stx_frame_receiver.sv
// Latency: a status item is presented the cycle after the EOT-position byte is accepted.
// Throughput: one received byte per cycle outside output bursts while no result item waits.
// Output burst: after an accepted frame, each payload item is a memory read then a load, and
//    output stalls hold the load; input is held off until the last payload item is loaded.
// Reset: synchronous; clears window, frame registers and output valid, broadcast address
//    returns to 0xFF. The payload memory is not cleared; only bytes of the current frame are read.
// ----------------------------------------------------------------------------
// soh_stx_frame_receiver
// Deframes SOH/STX/ETX/EOT byte frames with an additive checksum.
// ----------------------------------------------------------------------------
module soh_stx_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[1:0], dest_addr[9:2], sender_addr[17:10],
                                    // ack_flag[25:18], payload_len[31:26], byte_index[36:32],
                                    // payload_byte[44:37], zero[47:45]
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // bcast_addr
);
   import sfr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sfr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> test/soh_stx_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soh_stx_frame_receiver_test
// Self-checking bench for the frame receiver. A table of directed frames
// comes first: address and length extremes, zero-length frames, oversized
// headers, and missing ETX or EOT markers. Random frames follow, mostly well
// formed, some broken, with line noise between them and three broadcast
// address settings. A local model of the deframer predicts every status and
// payload item, and each item received is checked against it in order.
// ----------------------------------------------------------------------------
module soh_stx_frame_receiver_test;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int SHOWN_MAX     = 10;
   localparam int MAX_SENT_BODY = 40;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_ZEROS,
      FILL_ONES,
      FILL_RAMP
   } fill_kind_type;

   typedef enum logic [2:0] {
      FRM_CLEAN,
      FRM_BAD_SUM,
      FRM_NO_EOT,
      FRM_NO_ETX,
      FRM_CUT
   } frame_fault_type;

   typedef struct packed {
      logic [7:0]      dest;
      logic [7:0]      sender;
      logic [7:0]      ack;
      logic [7:0]      len;
      fill_kind_type   fill;
      frame_fault_type fault;
      logic [2:0]      lead;
      logic            typed;
      status_type      want;
   } frame_row_type;

   typedef struct packed {
      logic [2:0] pad;
      logic       kind;
      status_type status;
      logic [7:0] dest;
      logic [7:0] sender;
      logic [7:0] ack;
      logic [5:0] len;
      logic [4:0] idx;
      logic [7:0] data;
      logic       last;
   } frame_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // rx_byte[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // status[1:0], dest[9:2], sender[17:10], ack[25:18],
                                      // len[31:26], index[36:32], byte[44:37], zero[47:45]
   logic        rsp_tuser;            // kind
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = 8'h00;   // bcast_addr

   logic [7:0]  bcast_addr = BCAST_RST;
   logic [7:0]  hunt_win [0:WIN_LEN-1];
   phase_type   rx_phase;
   logic [5:0]  pay_pos;
   logic [5:0]  pay_len;
   logic [7:0]  hdr_dest;
   logic [7:0]  hdr_sender;
   logic [7:0]  hdr_ack;
   logic [7:0]  sum_calc;
   logic [7:0]  sum_rcvd;
   logic [7:0]  pay_mem [0:MAX_LEN-1];

   frame_item_type expected_items [$];
   frame_item_type got;
   frame_item_type want;
   frame_row_type  plan [16];

   int   bad_items   = 0;
   int   frame_bytes = 0;
   int   cycle_count = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic hold_ask    = 1'b0;
   logic steady      = 1'b0;

   soh_stx_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void restart_frame();
      rx_phase = PH_HUNT;
      pay_pos  = '0;
      pay_len  = '0;
      hdr_ack  = '0;
      sum_calc = '0;
      sum_rcvd = '0;
   endfunction

   function automatic void queue_item(logic kind, status_type st, logic [4:0] idx,
                                      logic [7:0] data, logic last);
      frame_item_type it;
      it.pad    = '0;
      it.kind   = kind;
      it.status = st;
      it.dest   = hdr_dest;
      it.sender = hdr_sender;
      it.ack    = hdr_ack;
      it.len    = pay_len;
      it.idx    = idx;
      it.data   = data;
      it.last   = last;
      expected_items.push_back(it);
   endfunction

   function automatic int deframe_byte(logic [7:0] b);
      int   n;
      int   i;
      logic addr_ok;
      n = 0;
      case (rx_phase)
         PH_PAYLOAD: begin
            if (pay_pos < MAX_LEN) pay_mem[pay_pos[4:0]] = b;
            sum_calc = sum_calc + b;
            pay_pos  = pay_pos + 6'd1;
            if (pay_pos >= pay_len) rx_phase = PH_ETX;
         end
         PH_ETX: begin
            if (b == CH_ETX) rx_phase = PH_CSUM;
            else restart_frame();
         end
         PH_CSUM: begin
            sum_rcvd = b;
            rx_phase = PH_EOT;
         end
         PH_EOT: begin
            if (b != CH_EOT) begin
               queue_item(KIND_STATUS, STAT_NO_EOT, '0, '0, 1'b1);
               n = 1;
            end else if (sum_rcvd != sum_calc) begin
               queue_item(KIND_STATUS, STAT_BAD_SUM, '0, '0, 1'b1);
               n = 1;
            end else begin
               queue_item(KIND_STATUS, STAT_ACCEPT, '0, '0, pay_len == 0);
               n = 1;
               for (i = 0; i < pay_len && i < MAX_LEN; i++) begin
                  queue_item(KIND_PAYLOAD, STAT_ACCEPT, i[4:0], pay_mem[i], i + 1 == pay_len);
                  n++;
               end
            end
            restart_frame();
         end
         default: begin
            for (i = 0; i < WIN_LEN - 1; i++) hunt_win[i] = hunt_win[i + 1];
            hunt_win[WIN_LEN - 1] = b;
            addr_ok = (hunt_win[2] == bcast_addr && hunt_win[3] == bcast_addr)
                      || hunt_win[2] != hunt_win[3];
            if (hunt_win[0] == CH_SOH && hunt_win[1] == FRAME_TYPE && hunt_win[6] == CH_STX
                && addr_ok && hunt_win[5] <= MAX_LEN) begin
               hdr_dest   = hunt_win[2];
               hdr_sender = hunt_win[3];
               hdr_ack    = hunt_win[4];
               pay_len    = hunt_win[5][5:0];
               sum_calc   = hunt_win[1] + hunt_win[2] + hunt_win[3] + hunt_win[4]
                            + hunt_win[5];
               pay_pos    = '0;
               rx_phase   = (pay_len == 0) ? PH_ETX : PH_PAYLOAD;
            end else begin
               rx_phase = PH_HUNT;
            end
         end
      endcase
      return n;
   endfunction

   function automatic string item_text(frame_item_type it);
      return $sformatf({"kind=%0d status=%0d dest=%02h sender=%02h ack=%02h len=%0d ",
                        "idx=%0d data=%02h last=%0d pad=%0d"},
                       it.kind, it.status, it.dest, it.sender, it.ack, it.len,
                       it.idx, it.data, it.last, it.pad);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic counted, output int n);
      while (!steady && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = deframe_byte(b);
      if (counted) frame_bytes++;
   endtask

   task automatic send_frame(input frame_row_type f);
      logic [7:0]     csum;
      logic [7:0]     b;
      frame_item_type tmp;
      int             n;
      int             cut;
      int             i;
      for (i = 0; i < f.lead; i++) send_byte(8'($urandom_range(255)), 1'b0, n);
      csum = FRAME_TYPE + f.dest + f.sender + f.ack + f.len;
      send_byte(CH_SOH, 1'b1, n);
      send_byte(FRAME_TYPE, 1'b1, n);
      send_byte(f.dest, 1'b1, n);
      send_byte(f.sender, 1'b1, n);
      send_byte(f.ack, 1'b1, n);
      send_byte(f.len, 1'b1, n);
      send_byte(CH_STX, 1'b1, n);
      cut = (f.len > MAX_SENT_BODY) ? MAX_SENT_BODY : f.len;
      if (f.fault == FRM_CUT) cut = $urandom_range(cut);
      for (i = 0; i < cut; i++) begin
         case (f.fill)
            FILL_ZEROS: b = 8'h00;
            FILL_ONES:  b = 8'hFF;
            FILL_RAMP:  b = i[7:0];
            default:    b = 8'($urandom_range(255));
         endcase
         csum = csum + b;
         send_byte(b, 1'b1, n);
      end
      if (f.fault != FRM_CUT) begin
         b = CH_ETX;
         if (f.fault == FRM_NO_ETX) begin
            b = 8'($urandom_range(255));
            if (b == CH_ETX) b ^= 8'h80;
         end
         send_byte(b, 1'b1, n);
         if (f.fault == FRM_BAD_SUM) csum = csum + 8'($urandom_range(1, 255));
         send_byte(csum, 1'b1, n);
         b = CH_EOT;
         if (f.fault == FRM_NO_EOT) begin
            b = 8'($urandom_range(255));
            if (b == CH_EOT) b ^= 8'h80;
         end
         send_byte(b, 1'b1, n);
         // pin the status code of the frame to the one given in the table
         if (f.typed && n > 0) begin
            tmp = expected_items[expected_items.size() - n];
            tmp.status = f.want;
            expected_items[expected_items.size() - n] = tmp;
         end
      end
   endtask

   task automatic random_frame();
      frame_row_type r;
      logic [7:0]    x;
      int            pick;
      int            n;
      int            k;
      if ($urandom_range(99) < 8) begin
         k = $urandom_range(1, 6);
         repeat (k) send_byte(8'($urandom_range(255)), 1'b0, n);
      end
      r.ack = 8'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick == 0) begin
         r.dest   = bcast_addr;
         r.sender = bcast_addr;
      end else if (pick == 1) begin
         x = 8'($urandom_range(255));
         if (x == bcast_addr) x ^= 8'h01;
         r.dest   = x;
         r.sender = x;
      end else begin
         r.dest   = 8'($urandom_range(255));
         r.sender = 8'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 70) r.len = 8'($urandom_range(8));
      else if (pick < 90) r.len = 8'($urandom_range(9, MAX_LEN - 1));
      else if (pick < 95) r.len = 8'(MAX_LEN);
      else r.len = 8'($urandom_range(MAX_LEN + 1, 255));
      pick = $urandom_range(99);
      r.fault = (pick < 70) ? FRM_CLEAN :
                (pick < 78) ? FRM_BAD_SUM :
                (pick < 86) ? FRM_NO_EOT :
                (pick < 93) ? FRM_NO_ETX : FRM_CUT;
      pick = $urandom_range(9);
      r.fill = (pick == 0) ? FILL_ZEROS :
               (pick == 1) ? FILL_ONES :
               (pick == 2) ? FILL_RAMP : FILL_RANDOM;
      r.lead  = ($urandom_range(99) < 30) ? 3'($urandom_range(1, 3)) : 3'd0;
      r.typed = 1'b0;
      r.want  = STAT_ACCEPT;
      send_frame(r);
   endtask

   task automatic random_block(input int target);
      int start;
      start = frame_bytes;
      while (frame_bytes - start < target) random_frame();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bcast(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      bcast_addr = v;
   endtask

   // hold off the result side once for a long stretch, otherwise stall at random unless steady is set
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_ask && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 17);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pad    = rsp_tdata[47:45];
         got.kind   = rsp_tuser;
         got.status = status_type'(rsp_tdata[1:0]);
         got.dest   = rsp_tdata[9:2];
         got.sender = rsp_tdata[17:10];
         got.ack    = rsp_tdata[25:18];
         got.len    = rsp_tdata[31:26];
         got.idx    = rsp_tdata[36:32];
         got.data   = rsp_tdata[44:37];
         got.last   = rsp_tlast;
         if (expected_items.size() == 0) begin
            if (bad_items < SHOWN_MAX)
               $display("unexpected item: %s", item_text(got));
            bad_items++;
         end else begin
            want = expected_items.pop_front();
            if (got.kind !== want.kind || got.status !== want.status
                || got.dest !== want.dest || got.sender !== want.sender
                || got.ack !== want.ack || got.len !== want.len
                || got.idx !== want.idx || got.data !== want.data
                || got.last !== want.last || got.pad !== want.pad) begin
               if (bad_items < SHOWN_MAX) begin
                  $display("item mismatch at cycle %0d", cycle_count);
                  $display("  expected %s", item_text(want));
                  $display("  actual   %s", item_text(got));
               end
               bad_items++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int i;
      for (i = 0; i < WIN_LEN; i++) hunt_win[i] = '0;
      for (i = 0; i < MAX_LEN; i++) pay_mem[i] = '0;
      hdr_dest   = '0;
      hdr_sender = '0;
      restart_frame();

      plan = '{
         '{8'h10, 8'h20, 8'h00, 8'd1,   FILL_RANDOM, FRM_CLEAN,   3'd0, 1'b1, STAT_ACCEPT},
         '{8'h00, 8'hFF, 8'hFF, 8'd0,   FILL_RANDOM, FRM_CLEAN,   3'd0, 1'b1, STAT_ACCEPT},
         '{8'hFF, 8'h00, 8'h80, 8'd32,  FILL_ONES,   FRM_CLEAN,   3'd0, 1'b1, STAT_ACCEPT},
         '{8'hFF, 8'hFF, 8'h01, 8'd3,   FILL_ZEROS,  FRM_CLEAN,   3'd0, 1'b1, STAT_ACCEPT},
         '{8'h33, 8'h33, 8'h02, 8'd2,   FILL_RANDOM, FRM_CLEAN,   3'd0, 1'b0, STAT_ACCEPT},
         '{8'h01, 8'h02, 8'h03, 8'd33,  FILL_RANDOM, FRM_CLEAN,   3'd0, 1'b0, STAT_ACCEPT},
         '{8'h05, 8'h06, 8'h07, 8'd255, FILL_RANDOM, FRM_CLEAN,   3'd2, 1'b0, STAT_ACCEPT},
         '{8'h12, 8'h34, 8'h56, 8'd4,   FILL_RANDOM, FRM_BAD_SUM, 3'd0, 1'b1, STAT_BAD_SUM},
         '{8'h21, 8'h43, 8'h65, 8'd4,   FILL_RANDOM, FRM_NO_EOT,  3'd0, 1'b1, STAT_NO_EOT},
         '{8'h7F, 8'h80, 8'h00, 8'd0,   FILL_RANDOM, FRM_BAD_SUM, 3'd0, 1'b1, STAT_BAD_SUM},
         '{8'h80, 8'h7F, 8'hFF, 8'd0,   FILL_RANDOM, FRM_NO_EOT,  3'd0, 1'b1, STAT_NO_EOT},
         '{8'h0F, 8'hF0, 8'h11, 8'd5,   FILL_RANDOM, FRM_NO_ETX,  3'd0, 1'b0, STAT_ACCEPT},
         '{8'hF0, 8'h0F, 8'h22, 8'd5,   FILL_RAMP,   FRM_CLEAN,   3'd3, 1'b1, STAT_ACCEPT},
         '{8'hAA, 8'h55, 8'h04, 8'd31,  FILL_RANDOM, FRM_CLEAN,   3'd0, 1'b1, STAT_ACCEPT},
         '{8'h55, 8'hAA, 8'hFE, 8'd7,   FILL_RAMP,   FRM_CUT,     3'd0, 1'b0, STAT_ACCEPT},
         '{8'h01, 8'h02, 8'h55, 8'd2,   FILL_ZEROS,  FRM_CLEAN,   3'd0, 1'b0, STAT_ACCEPT}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 16; i++) send_frame(plan[i]);

      drain();
      write_bcast(8'h00);
      steady = 1'b1;
      random_block(40);
      steady = 1'b0;

      drain();
      write_bcast(8'($urandom_range(1, 254)));
      hold_ask = 1'b1;
      random_block(25);

      drain();
      write_bcast(8'hFF);
      random_block(20);

      drain();
      if (bad_items == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_ram.sv
rtl/core/sfr_ctrl.sv
rtl/core/sfr_datapath.sv
rtl/core/soh_stx_frame_receiver.sv
test/soh_stx_frame_receiver_test.sv
